@@ src/uer_pkg.sv @@
package uer_pkg;

    // Payload of one input word: one microsecond tick.
    typedef struct packed {
        logic start_req;
        logic echo;
    } t_in_word;

    // Payload of one result word.
    typedef struct packed {
        logic        trigger;
        logic        busy_res;
        logic        done_res;
        logic        timed_out;
        logic [15:0] distance_cm;
    } t_out_word;

    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_TIMEOUT  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_TIMEOUT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_CM  = 8'd3;

    // Reset values of the configuration registers.
    localparam logic [9:0]  RST_TRIGGER_TICKS = 10'd10;
    localparam logic [15:0] RST_RISE_TIMEOUT  = 16'd30000;
    localparam logic [15:0] RST_WIDTH_TIMEOUT = 16'd38000;
    localparam logic [7:0]  RST_TICKS_PER_CM  = 8'd58;

    // Largest reported distance; larger quotients saturate here.
    localparam logic [15:0] DIST_MAX = 16'hFFFF;

    // Measurement phase.
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_TRIG = 4'b0010,
        PH_WAIT = 4'b0100,
        PH_MEAS = 4'b1000
    } t_phase;

    // Sequencer around the divider.
    typedef enum logic [1:0] {
        SEQ_IDLE = 2'b01,
        SEQ_DIV  = 2'b10
    } t_seq;

endpackage

@@ src/uer_if.sv @@
// Input tick channel.
interface uer_in_if;
    logic              valid;
    logic              ready;
    uer_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Result channel.
interface uer_out_if;
    logic               valid;
    logic               ready;
    uer_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Configuration write channel.
interface uer_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [uer_pkg::CFG_IDX_W-1:0]  index;
    logic [uer_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/ultrasonic_echo_ranger.sv @@
// Channel   Dir  Modport  Payload
// i_in      in   sink     start_req, echo (one word per microsecond tick)
// o_out     out  source   trigger, busy_res, done_res, timed_out, distance_cm
// i_cfg     in   sink     index, data (trigger_ticks, rise_timeout, width_timeout,
//                         ticks_per_cm at indexes 0 to 3)
//
// A tick is taken on a handshake and its result word is registered at the accepting edge.
// The tick that ends a measurement runs a restoring divider, one quotient
// bit per cycle, and no further word is taken until the quotient is registered.
// Input is accepted only while the divider is free and the result register is
// empty or being drained; a stalled result holds its word.
// Reset (i_rst_n low, synchronous) loads the default register values and idles.
module ultrasonic_echo_ranger #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    uer_in_if.sink    i_in,
    uer_out_if.source o_out,
    uer_cfg_if.sink   i_cfg
);
    import uer_pkg::*;

    localparam int unsigned CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam int unsigned QW    = (COUNT_BITS > 16) ? COUNT_BITS : 17;
    localparam int unsigned CNT_W = $clog2(COUNT_BITS + 1);

    // Configuration registers.
    logic [9:0]  r_trigger_ticks;
    logic [15:0] r_rise_timeout;
    logic [15:0] r_width_timeout;
    logic [7:0]  r_ticks_per_cm;

    // Measurement state.
    t_phase                r_phase, n_phase;
    logic [COUNT_BITS-1:0] r_count, n_count;

    // Divider and sequencer.
    t_seq                  r_seq;
    logic [7:0]            r_rem;
    logic [7:0]            r_div;
    logic [COUNT_BITS-1:0] r_quo;
    logic [CNT_W-1:0]      r_bit_cnt;

    // Result register.
    logic      r_out_valid;
    t_out_word r_out;

    logic                  in_accept;
    logic                  launch;
    t_out_word             step_word;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [CMP_W-1:0]      tlen_ext;
    logic [8:0]            rem_sh;
    logic [8:0]            rem_diff;
    logic                  rem_ge;
    logic [15:0]           div_dist;

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_ticks <= RST_TRIGGER_TICKS;
            r_rise_timeout  <= RST_RISE_TIMEOUT;
            r_width_timeout <= RST_WIDTH_TIMEOUT;
            r_ticks_per_cm  <= RST_TICKS_PER_CM;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_TRIGGER_TICKS: r_trigger_ticks <= i_cfg.data[9:0];
                CFG_RISE_TIMEOUT:  r_rise_timeout  <= i_cfg.data;
                CFG_WIDTH_TIMEOUT: r_width_timeout <= i_cfg.data;
                CFG_TICKS_PER_CM:  r_ticks_per_cm  <= i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

    // Handshakes.
    assign i_in.ready  = (r_seq == SEQ_IDLE) && (!r_out_valid || o_out.ready);
    assign in_accept   = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Saturating phase counter increment; a zero trigger length acts as one.
    assign cnt_inc  = (r_count == '1) ? r_count : r_count + 1'b1;
    assign tlen_ext = (r_trigger_ticks == '0) ? CMP_W'(1) : CMP_W'(r_trigger_ticks);

    // Phase update for one tick.
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        launch    = 1'b0;
        step_word = '0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_in.data.start_req) begin
                    step_word.trigger = 1'b1;
                    if (CMP_W'(1) >= tlen_ext) begin
                        n_phase = PH_WAIT;
                        n_count = '0;
                    end else begin
                        n_phase = PH_TRIG;
                        n_count = COUNT_BITS'(1);
                    end
                end
            end
            PH_TRIG: begin
                step_word.trigger = 1'b1;
                if (CMP_W'(cnt_inc) >= tlen_ext) begin
                    n_phase = PH_WAIT;
                    n_count = '0;
                end else begin
                    n_count = cnt_inc;
                end
            end
            PH_WAIT: begin
                if (i_in.data.echo) begin
                    n_phase = PH_MEAS;
                    n_count = COUNT_BITS'(1);
                end else if (CMP_W'(cnt_inc) > CMP_W'(r_rise_timeout)) begin
                    step_word.done_res  = 1'b1;
                    step_word.timed_out = 1'b1;
                    n_phase = PH_IDLE;
                    n_count = '0;
                end else begin
                    n_count = cnt_inc;
                end
            end
            PH_MEAS: begin
                if (i_in.data.echo) begin
                    if (CMP_W'(cnt_inc) > CMP_W'(r_width_timeout)) begin
                        step_word.done_res  = 1'b1;
                        step_word.timed_out = 1'b1;
                        n_phase = PH_IDLE;
                        n_count = '0;
                    end else begin
                        n_count = cnt_inc;
                    end
                end else begin
                    // Echo fell: the distance comes from the divider.
                    launch  = 1'b1;
                    n_phase = PH_IDLE;
                    n_count = '0;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_count = '0;
            end
        endcase
        step_word.busy_res = (n_phase != PH_IDLE);
    end

    // One restoring division step: shift in the next dividend bit, subtract if it fits.
    assign rem_sh   = {r_rem, r_quo[COUNT_BITS-1]};
    assign rem_diff = rem_sh - {1'b0, r_div};
    assign rem_ge   = (rem_sh >= {1'b0, r_div});
    assign div_dist = (QW'(r_quo) > QW'(DIST_MAX)) ? DIST_MAX : 16'(r_quo);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_seq       <= SEQ_IDLE;
            r_bit_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_phase <= n_phase;
                r_count <= n_count;
            end
            unique case (r_seq)
                SEQ_IDLE: begin
                    if (in_accept && launch) begin
                        r_seq     <= SEQ_DIV;
                        r_bit_cnt <= CNT_W'(COUNT_BITS);
                    end
                end
                SEQ_DIV: begin
                    if (r_bit_cnt == '0) begin
                        r_seq <= SEQ_IDLE;
                    end else begin
                        r_bit_cnt <= r_bit_cnt - 1'b1;
                    end
                end
                default: r_seq <= SEQ_IDLE;
            endcase
            if ((in_accept && !launch) || (r_seq == SEQ_DIV && r_bit_cnt == '0)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Divider datapath and result word.
    always_ff @(posedge i_clk) begin
        if (in_accept && launch) begin
            r_quo <= r_count;
            r_rem <= '0;
            r_div <= (r_ticks_per_cm == '0) ? 8'd1 : r_ticks_per_cm;
        end else if (r_seq == SEQ_DIV && r_bit_cnt != '0) begin
            r_quo <= {r_quo[COUNT_BITS-2:0], rem_ge};
            r_rem <= rem_ge ? rem_diff[7:0] : rem_sh[7:0];
        end
        if (in_accept && !launch) begin
            r_out <= step_word;
        end else if (r_seq == SEQ_DIV && r_bit_cnt == '0) begin
            r_out <= '{trigger: 1'b0, busy_res: 1'b0, done_res: 1'b1,
                       timed_out: 1'b0, distance_cm: div_dist};
        end
    end

endmodule
